### src/crt_pkg.sv
// ----------------------------------------------------------------------------
// crt_pkg
// Shared codes and controller/datapath interface types of the replacement
// tracker.
// ----------------------------------------------------------------------------
package crt_pkg;

    localparam int VICTIM_W  = 28;
    localparam int OUTCOME_W = 2;
    localparam int CFG_W     = 4;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAPPING    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POLICY     = 2'd2;

    // Mapping modes. The reserved code behaves as direct mapped.
    localparam logic [1:0] MAP_DIRECT   = 2'd0;
    localparam logic [1:0] MAP_FOUR     = 2'd1;
    localparam logic [1:0] MAP_FULL     = 2'd2;
    localparam logic [1:0] MAP_RESERVED = 2'd3;

    // Replacement policies. The reserved code behaves as FIFO.
    localparam logic [1:0] POL_FIFO     = 2'd0;
    localparam logic [1:0] POL_LRU      = 2'd1;
    localparam logic [1:0] POL_SC       = 2'd2;
    localparam logic [1:0] POL_RESERVED = 2'd3;

    // Outcome codes.
    localparam logic [OUTCOME_W-1:0] OUT_HIT   = 2'd0;
    localparam logic [OUTCOME_W-1:0] OUT_FILL  = 2'd1;
    localparam logic [OUTCOME_W-1:0] OUT_EVICT = 2'd2;

    // Way selects for line store addressing.
    localparam logic [1:0] WAY_IDX  = 2'd0;
    localparam logic [1:0] WAY_PTR  = 2'd1;
    localparam logic [1:0] WAY_PREV = 2'd2;

    // Line store write data selects.
    localparam logic [2:0] WD_ZERO     = 3'd0;
    localparam logic [2:0] WD_HOLD_REF = 3'd1;
    localparam logic [2:0] WD_Q_NOREF  = 3'd2;
    localparam logic [2:0] WD_FILL     = 3'd3;
    localparam logic [2:0] WD_Q        = 3'd4;
    localparam logic [2:0] WD_HOLD     = 3'd5;

    typedef struct packed {
        logic       clear;
        logic       load;
        logic       widx_inc;
        logic       widx_dec;
        logic       widx_load_p;
        logic       hold_ld;
        logic       p_load;
        logic       p_inc;
        logic       fill_commit;
        logic       ptr_wr;
        logic       wr_en;
        logic [2:0] wr_sel;
        logic [1:0] wr_way;
        logic [1:0] rd_way;
    } cmd_t;

    typedef struct packed {
        logic match;
        logic last_way;
        logic widx_zero;
        logic widx_one;
        logic clr_last;
        logic sc_ref;
        logic lru;
        logic sc;
    } status_t;

endpackage

### src/crt_ctrl.sv
// ----------------------------------------------------------------------------
// crt_ctrl
// Sequencer for lookup, policy update, victim selection and clearing pass.
// ----------------------------------------------------------------------------
module crt_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  crt_pkg::status_t status,
    output crt_pkg::cmd_t    cmd,
    output logic             busy,
    output logic             done
);

    localparam logic [3:0] S_CLEAR    = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_LK_RD    = 4'd2;
    localparam logic [3:0] S_LK_CMP   = 4'd3;
    localparam logic [3:0] S_HIT      = 4'd4;
    localparam logic [3:0] S_MTF_RD   = 4'd5;
    localparam logic [3:0] S_MTF_WR   = 4'd6;
    localparam logic [3:0] S_MTF_LAST = 4'd7;
    localparam logic [3:0] S_PTR_RD   = 4'd8;
    localparam logic [3:0] S_PTR_Q    = 4'd9;
    localparam logic [3:0] S_SC_RD    = 4'd10;
    localparam logic [3:0] S_SC_CMP   = 4'd11;
    localparam logic [3:0] S_VIC_RD   = 4'd12;
    localparam logic [3:0] S_VIC_WR   = 4'd13;
    localparam logic [3:0] S_PTR_WR   = 4'd14;
    localparam logic [3:0] S_DONE     = 4'd15;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       miss_reg;
    logic       miss_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            miss_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            miss_reg  <= miss_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        miss_next  = miss_reg;
        cmd        = '0;
        cmd.wr_sel = crt_pkg::WD_ZERO;
        cmd.wr_way = crt_pkg::WAY_IDX;
        cmd.rd_way = crt_pkg::WAY_IDX;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear  = 1'b1;
                cmd.wr_en  = 1'b1;
                cmd.ptr_wr = 1'b1;
                if (status.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    miss_next  = 1'b0;
                    state_next = S_LK_RD;
                end
            end
            S_LK_RD:
            begin
                state_next = S_LK_CMP;
            end
            S_LK_CMP:
            begin
                if (status.match)
                begin
                    cmd.hold_ld = 1'b1;
                    state_next  = S_HIT;
                end
                else if (status.last_way)
                begin
                    miss_next  = 1'b1;
                    state_next = S_PTR_RD;
                end
                else
                begin
                    cmd.widx_inc = 1'b1;
                    state_next   = S_LK_RD;
                end
            end
            S_HIT:
            begin
                if (status.sc)
                begin
                    cmd.wr_en  = 1'b1;
                    cmd.wr_sel = crt_pkg::WD_HOLD_REF;
                    state_next = S_DONE;
                end
                else if (status.lru && !status.widx_zero)
                begin
                    state_next = S_MTF_RD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_MTF_RD:
            begin
                cmd.rd_way = crt_pkg::WAY_PREV;
                state_next = S_MTF_WR;
            end
            S_MTF_WR:
            begin
                cmd.wr_en    = 1'b1;
                cmd.wr_sel   = crt_pkg::WD_Q;
                cmd.widx_dec = 1'b1;
                state_next   = status.widx_one ? S_MTF_LAST : S_MTF_RD;
            end
            S_MTF_LAST:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = crt_pkg::WD_HOLD;
                state_next = miss_reg ? S_PTR_WR : S_DONE;
            end
            S_PTR_RD:
            begin
                state_next = S_PTR_Q;
            end
            S_PTR_Q:
            begin
                cmd.p_load = 1'b1;
                state_next = status.sc ? S_SC_RD : S_VIC_RD;
            end
            S_SC_RD:
            begin
                cmd.rd_way = crt_pkg::WAY_PTR;
                state_next = S_SC_CMP;
            end
            S_SC_CMP:
            begin
                if (status.sc_ref)
                begin
                    cmd.wr_en  = 1'b1;
                    cmd.wr_sel = crt_pkg::WD_Q_NOREF;
                    cmd.wr_way = crt_pkg::WAY_PTR;
                    cmd.p_inc  = 1'b1;
                    state_next = S_SC_RD;
                end
                else
                begin
                    state_next = S_VIC_RD;
                end
            end
            S_VIC_RD:
            begin
                cmd.rd_way      = crt_pkg::WAY_PTR;
                cmd.widx_load_p = 1'b1;
                state_next      = S_VIC_WR;
            end
            S_VIC_WR:
            begin
                cmd.wr_en       = 1'b1;
                cmd.wr_sel      = crt_pkg::WD_FILL;
                cmd.fill_commit = 1'b1;
                state_next = (status.lru && !status.widx_zero) ? S_MTF_RD : S_PTR_WR;
            end
            S_PTR_WR:
            begin
                cmd.ptr_wr = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);

endmodule

### src/crt_datapath.sv
// ----------------------------------------------------------------------------
// crt_datapath
// Configuration, address split, line and pointer stores, and result registers.
// ----------------------------------------------------------------------------
module crt_datapath #(
    parameter int MAX_LINES_LOG2 = 10,
    parameter int OFFSET_BITS    = 4,
    parameter int ADDRESS_BITS   = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [crt_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [crt_pkg::CFG_W-1:0]           cfg_data,
    input  logic [31:0]                         address,
    input  crt_pkg::cmd_t                       cmd,
    output crt_pkg::status_t                    status,
    output logic [crt_pkg::OUTCOME_W-1:0]       outcome,
    output logic [crt_pkg::VICTIM_W-1:0]        victim_tag
);

    localparam int M     = MAX_LINES_LOG2;
    localparam int LINES = 1 << M;
    localparam int ABITS = (ADDRESS_BITS < 32) ? ADDRESS_BITS : 32;
    localparam int TAG_W = ABITS - OFFSET_BITS;
    localparam int BLK_W = (TAG_W > M) ? TAG_W : M;
    localparam int LW    = TAG_W + 2;
    localparam int LG_W  = $clog2(M + 1);
    localparam int VW    = crt_pkg::VICTIM_W;

    logic [crt_pkg::CFG_W-1:0] lg_cfg_reg;
    logic [1:0]                mode_reg;
    logic [1:0]                policy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lg_cfg_reg <= 4'd10;
            mode_reg   <= crt_pkg::MAP_DIRECT;
            policy_reg <= crt_pkg::POL_FIFO;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                crt_pkg::CFG_LINE_COUNT: lg_cfg_reg <= cfg_data;
                crt_pkg::CFG_MAPPING:    mode_reg   <= cfg_data[1:0];
                crt_pkg::CFG_POLICY:     policy_reg <= cfg_data[1:0];
                default:                 lg_cfg_reg <= lg_cfg_reg;
            endcase
        end
    end

    // Geometry of the current split.
    logic [LG_W-1:0] lg;
    logic [LG_W-1:0] abits;
    logic [LG_W-1:0] ibits;

    always_comb
    begin
        if (lg_cfg_reg < 4'd2)
        begin
            lg = LG_W'(2);
        end
        else if (32'(lg_cfg_reg) > M)
        begin
            lg = LG_W'(M);
        end
        else
        begin
            lg = LG_W'(lg_cfg_reg);
        end
        case (mode_reg)
            crt_pkg::MAP_FOUR: abits = LG_W'(2);
            crt_pkg::MAP_FULL: abits = lg;
            default:           abits = '0;
        endcase
        ibits = lg - abits;
    end

    logic [M+TAG_W-1:0] blk_ext;
    logic [BLK_W-1:0]   blk;
    logic [BLK_W-1:0]   blk_shift;
    logic [M-1:0]       set_in;
    logic [M-1:0]       wmask_in;

    assign blk_ext   = {{M{1'b0}}, address[ABITS-1:OFFSET_BITS]};
    assign blk       = blk_ext[BLK_W-1:0];
    assign blk_shift = blk >> ibits;
    assign set_in    = blk[M-1:0] & ~({M{1'b1}} << ibits);
    assign wmask_in  = ~({M{1'b1}} << abits);

    logic [TAG_W-1:0]             tag_reg;
    logic [M-1:0]                 set_reg;
    logic [M-1:0]                 base_reg;
    logic [M-1:0]                 wmask_reg;
    logic [M-1:0]                 widx_reg;
    logic [M-1:0]                 p_reg;
    logic [M:0]                   cnt_reg;
    logic [LW-1:0]                hold_reg;
    logic [crt_pkg::OUTCOME_W-1:0] outcome_reg;
    logic [VW-1:0]                victim_reg;
    logic [LW-1:0]                line_q;
    logic [M-1:0]                 ptr_q;

    logic [LW-1:0] fill_word;
    logic [M:0]    ways;
    logic [VW+TAG_W-1:0] victim_ext;

    assign fill_word  = {1'b1, line_q[LW-2], tag_reg};
    assign ways       = {1'b0, wmask_reg} + 1'b1;
    assign victim_ext = {{VW{1'b0}}, line_q[TAG_W-1:0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            widx_reg <= '0;
        end
        else if (cmd.clear || cmd.widx_inc)
        begin
            widx_reg <= widx_reg + 1'b1;
        end
        else if (cmd.widx_dec)
        begin
            widx_reg <= widx_reg - 1'b1;
        end
        else if (cmd.widx_load_p)
        begin
            widx_reg <= p_reg & wmask_reg;
        end
        else if (cmd.load)
        begin
            widx_reg <= '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            tag_reg     <= blk_shift[TAG_W-1:0];
            set_reg     <= set_in;
            base_reg    <= set_in << abits;
            wmask_reg   <= wmask_in;
            outcome_reg <= crt_pkg::OUT_HIT;
            victim_reg  <= '0;
        end
        if (cmd.hold_ld)
        begin
            hold_reg <= line_q;
        end
        if (cmd.p_load)
        begin
            p_reg   <= ptr_q;
            cnt_reg <= '0;
        end
        else if (cmd.p_inc)
        begin
            p_reg   <= p_reg + 1'b1;
            cnt_reg <= cnt_reg + 1'b1;
        end
        else if (cmd.fill_commit)
        begin
            // The pointer value for this set is settled when the line is filled.
            if (policy_reg == crt_pkg::POL_LRU)
            begin
                p_reg <= (widx_reg != wmask_reg) ? widx_reg + 1'b1 : widx_reg;
            end
            else
            begin
                p_reg <= p_reg + 1'b1;
            end
        end
        if (cmd.fill_commit)
        begin
            hold_reg <= fill_word;
            if (line_q[LW-1])
            begin
                outcome_reg <= crt_pkg::OUT_EVICT;
                victim_reg  <= victim_ext[VW-1:0];
            end
            else
            begin
                outcome_reg <= crt_pkg::OUT_FILL;
                victim_reg  <= '0;
            end
        end
    end

    // Line store addressing and write data.
    logic [M-1:0]  rd_way;
    logic [M-1:0]  wr_way;
    logic [M-1:0]  rd_addr;
    logic [M-1:0]  wr_addr;
    logic [LW-1:0] wr_data;

    always_comb
    begin
        case (cmd.rd_way)
            crt_pkg::WAY_PTR:  rd_way = p_reg;
            crt_pkg::WAY_PREV: rd_way = widx_reg - 1'b1;
            default:           rd_way = widx_reg;
        endcase
        wr_way  = (cmd.wr_way == crt_pkg::WAY_PTR) ? p_reg : widx_reg;
        rd_addr = base_reg | (rd_way & wmask_reg);
        wr_addr = cmd.clear ? widx_reg : (base_reg | (wr_way & wmask_reg));
        case (cmd.wr_sel)
            crt_pkg::WD_HOLD_REF: wr_data = {hold_reg[LW-1], 1'b1, hold_reg[TAG_W-1:0]};
            crt_pkg::WD_Q_NOREF:  wr_data = {line_q[LW-1], 1'b0, line_q[TAG_W-1:0]};
            crt_pkg::WD_FILL:     wr_data = fill_word;
            crt_pkg::WD_Q:        wr_data = line_q;
            crt_pkg::WD_HOLD:     wr_data = hold_reg;
            default:              wr_data = '0;
        endcase
    end

    logic [LW-1:0] line_mem [LINES];
    logic [M-1:0]  ptr_mem  [LINES];

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            line_mem[wr_addr] <= wr_data;
        end
        line_q <= line_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ptr_wr)
        begin
            ptr_mem[cmd.clear ? widx_reg : set_reg] <= cmd.clear ? '0 : p_reg;
        end
        ptr_q <= ptr_mem[set_reg];
    end

    always_comb
    begin
        status.match     = line_q[LW-1] && (line_q[TAG_W-1:0] == tag_reg);
        status.last_way  = (widx_reg == wmask_reg);
        status.widx_zero = (widx_reg == '0);
        status.widx_one  = (widx_reg == M'(1));
        status.clr_last  = &widx_reg;
        status.sc_ref    = line_q[LW-2] && (cnt_reg != ways);
        status.lru       = (policy_reg == crt_pkg::POL_LRU);
        status.sc        = (policy_reg == crt_pkg::POL_SC);
    end

    assign outcome    = outcome_reg;
    assign victim_tag = victim_reg;

endmodule

### src/cache_replacement_tracker.sv
// ----------------------------------------------------------------------------
// cache_replacement_tracker
// Per-set tag lookup with FIFO, LRU and second-chance replacement tracking.
// ----------------------------------------------------------------------------
// Before done, the lookup reads and compares each way searched. A hit then
// sets its reference bit under second chance, and LRU moves it to the front.
// A miss reads the set's pointer, tests and clears reference bits under
// second chance, writes the fill, moves the filled way to the front under
// LRU and writes the pointer back. One word in flight; busy drops the cycle
// after done. Results never stall. Reset clears all lines with busy high.
// ----------------------------------------------------------------------------
module cache_replacement_tracker #(
    parameter int MAX_LINES_LOG2 = 10,
    parameter int OFFSET_BITS    = 4,
    parameter int ADDRESS_BITS   = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [crt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [crt_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          start,
    input  logic [31:0]                   address,
    output logic                          busy,
    output logic                          done,
    output logic [crt_pkg::OUTCOME_W-1:0] outcome,
    output logic [crt_pkg::VICTIM_W-1:0]  victim_tag
);

    crt_pkg::cmd_t    cmd;
    crt_pkg::status_t status;

    crt_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    crt_datapath #(
        .MAX_LINES_LOG2 (MAX_LINES_LOG2),
        .OFFSET_BITS    (OFFSET_BITS),
        .ADDRESS_BITS   (ADDRESS_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .address    (address),
        .cmd        (cmd),
        .status     (status),
        .outcome    (outcome),
        .victim_tag (victim_tag)
    );

endmodule

### bench/tb_cache_replacement_tracker.sv
// ----------------------------------------------------------------------------
// tb_cache_replacement_tracker
// Drives address words through the replacement tracker under every mapping
// mode and policy, predicts hit, fill and eviction per word, and checks each
// done strobe against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_cache_replacement_tracker;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINES_LOG2 = 10;
    localparam int LINES      = 1 << LINES_LOG2;
    localparam int OFFSET     = 4;
    localparam longint CYCLE_LIMIT = 12000000;

    typedef struct packed {
        logic [crt_pkg::OUTCOME_W-1:0] outcome;
        logic [crt_pkg::VICTIM_W-1:0]  victim_tag;
    } access_result_t;

    // Scoreboard: a copy of the tracker state plus the pending outcomes.
    class replacement_scoreboard;
        logic [31:0] tags [LINES];
        bit          valid [LINES];
        bit          refb [LINES];
        logic [9:0]  ptr [LINES];
        logic [3:0]  lines_log2;
        logic [1:0]  mapping;
        logic [1:0]  policy;
        access_result_t pending [$];
        int errors;
        int hits;
        int fills;
        int evicts;

        function void clear();
            for (int i = 0; i < LINES; i++)
            begin
                tags[i] = '0;
                valid[i] = 1'b0;
                refb[i] = 1'b0;
                ptr[i] = '0;
            end
            lines_log2 = 4'd10;
            mapping = crt_pkg::MAP_DIRECT;
            policy = crt_pkg::POL_FIFO;
            pending.delete();
            errors = 0;
            hits = 0;
            fills = 0;
            evicts = 0;
        endfunction

        function void set_register(logic [crt_pkg::CFG_IDX_W-1:0] idx,
                                   logic [crt_pkg::CFG_W-1:0] val);
            if (idx == crt_pkg::CFG_LINE_COUNT)
                lines_log2 = val;
            else if (idx == crt_pkg::CFG_MAPPING)
                mapping = val[1:0];
            else if (idx == crt_pkg::CFG_POLICY)
                policy = val[1:0];
        endfunction

        function void promote(int base, int k);
            logic [31:0] t;
            bit v;
            bit r;
            t = tags[base + k];
            v = valid[base + k];
            r = refb[base + k];
            for (int j = k; j >= 1; j--)
            begin
                tags[base + j] = tags[base + j - 1];
                valid[base + j] = valid[base + j - 1];
                refb[base + j] = refb[base + j - 1];
            end
            tags[base] = t;
            valid[base] = v;
            refb[base] = r;
        endfunction

        function void note_access(logic [31:0] addr);
            int lg;
            int abits;
            int ibits;
            int ways;
            int set_idx;
            int base;
            int hit_way;
            int way;
            logic [1:0] pol;
            logic [31:0] blk;
            logic [31:0] tag;
            logic [9:0] p;
            access_result_t res;
            lg = int'(lines_log2);
            if (lg < 2)
                lg = 2;
            if (lg > LINES_LOG2)
                lg = LINES_LOG2;
            if (mapping == crt_pkg::MAP_FOUR)
                abits = 2;
            else if (mapping == crt_pkg::MAP_FULL)
                abits = lg;
            else
                abits = 0;
            ibits = lg - abits;
            ways = 1 << abits;
            pol = (policy == crt_pkg::POL_RESERVED) ? crt_pkg::POL_FIFO : policy;
            blk = addr >> OFFSET;
            set_idx = blk & ((1 << ibits) - 1);
            tag = blk >> ibits;
            base = set_idx << abits;
            hit_way = -1;
            for (int i = 0; i < ways; i++)
            begin
                if (hit_way < 0 && valid[base + i] && tags[base + i] == tag)
                    hit_way = i;
            end
            res = '0;
            if (hit_way >= 0)
            begin
                if (pol == crt_pkg::POL_LRU)
                    promote(base, hit_way);
                else if (pol == crt_pkg::POL_SC)
                    refb[base + hit_way] = 1'b1;
                res.outcome = crt_pkg::OUT_HIT;
                hits++;
            end
            else
            begin
                p = ptr[set_idx];
                if (pol == crt_pkg::POL_SC)
                begin
                    for (int n = 0; n < ways && refb[base + (p & (ways - 1))]; n++)
                    begin
                        refb[base + (p & (ways - 1))] = 1'b0;
                        p = p + 1'b1;
                    end
                end
                way = p & (ways - 1);
                if (valid[base + way])
                begin
                    res.outcome = crt_pkg::OUT_EVICT;
                    res.victim_tag = tags[base + way][crt_pkg::VICTIM_W-1:0];
                    evicts++;
                end
                else
                begin
                    res.outcome = crt_pkg::OUT_FILL;
                    fills++;
                end
                tags[base + way] = tag;
                valid[base + way] = 1'b1;
                if (pol == crt_pkg::POL_LRU)
                begin
                    promote(base, way);
                    ptr[set_idx] = 10'((way != ways - 1) ? way + 1 : way);
                end
                else
                    ptr[set_idx] = p + 1'b1;
            end
            pending.push_back(res);
        endfunction

        function void check_result(logic [crt_pkg::OUTCOME_W-1:0] oc,
                                   logic [crt_pkg::VICTIM_W-1:0] vt);
            access_result_t exp_res;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result outcome=%0d victim=%h", $realtime, oc, vt);
                errors++;
                return;
            end
            exp_res = pending.pop_front();
            if (oc !== exp_res.outcome)
            begin
                $display("%0t: outcome expected %0d actual %0d", $realtime,
                         exp_res.outcome, oc);
                errors++;
            end
            if (vt !== exp_res.victim_tag)
            begin
                $display("%0t: victim_tag expected %h actual %h", $realtime,
                         exp_res.victim_tag, vt);
                errors++;
            end
        endfunction
    endclass

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_write;
    logic [crt_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [crt_pkg::CFG_W-1:0]     cfg_data;
    logic                          start;
    logic [31:0]                   address;
    logic                          busy;
    logic                          done;
    logic [crt_pkg::OUTCOME_W-1:0] outcome;
    logic [crt_pkg::VICTIM_W-1:0]  victim_tag;

    replacement_scoreboard sb;
    longint cycle_count;
    int words_sent;
    logic [31:0] hot_addrs [8];

    cache_replacement_tracker u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .start      (start),
        .address    (address),
        .busy       (busy),
        .done       (done),
        .outcome    (outcome),
        .victim_tag (victim_tag)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (rst_n && done)
            sb.check_result(outcome, victim_tag);
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[cache_replacement_tracker] ERROR");
            $finish;
        end
    end

    // The trailing edge keeps start from being driven twice in one step.
    task automatic send_word(logic [31:0] addr);
        start <= 1'b1;
        address <= addr;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_access(addr);
        words_sent++;
        start <= 1'b0;
        @(posedge clk);
    endtask

    task automatic idle_gap();
        int n;
        if ($urandom_range(0, 99) < 40)
            n = 0;
        else if ($urandom_range(0, 99) < 90)
            n = $urandom_range(1, 4);
        else
            n = $urandom_range(20, 80);
        repeat (n) @(posedge clk);
    endtask

    task automatic drain();
        while (sb.pending.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [crt_pkg::CFG_IDX_W-1:0] idx,
                             logic [crt_pkg::CFG_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        sb.set_register(idx, val);
    endtask

    task automatic configure(logic [3:0] lg, logic [1:0] mode, logic [1:0] pol);
        drain();
        write_reg(crt_pkg::CFG_LINE_COUNT, lg);
        write_reg(crt_pkg::CFG_MAPPING, {2'b00, mode});
        write_reg(crt_pkg::CFG_POLICY, {2'b00, pol});
        cfg_write <= 1'b0;
    endtask

    // Mostly reuse a small pool of addresses so that sets fill, hit and evict.
    function automatic logic [31:0] pick_address();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return hot_addrs[$urandom_range(0, 7)] ^ $urandom_range(0, 15);
        else if (r < 85)
            return (32'($urandom_range(0, 31)) << 4) | (32'($urandom_range(0, 7)) << 12);
        else
            return $urandom();
    endfunction

    initial
    begin
        logic [3:0] lg;
        logic [1:0] mode;
        logic [1:0] pol;
        sb = new();
        sb.clear();
        cycle_count = 0;
        words_sent = 0;
        cfg_write = 1'b0;
        cfg_index = crt_pkg::CFG_LINE_COUNT;
        cfg_data = '0;
        start = 1'b0;
        address = '0;
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: field extremes, tag zero, same-set conflicts, reuse.
        send_word(32'h0000_0000);
        send_word(32'hFFFF_FFFF);
        send_word(32'h0000_000F);
        send_word(32'h0000_4000);
        send_word(32'h0000_0000);
        send_word(32'h8000_0000);
        configure(4'd2, crt_pkg::MAP_FOUR, crt_pkg::POL_LRU);
        send_word(32'h0000_0000);
        send_word(32'h0000_0040);
        send_word(32'h0000_0080);
        send_word(32'h0000_00C0);
        send_word(32'h0000_0000);
        send_word(32'h0000_0100);
        send_word(32'hFFFF_FFF0);
        configure(4'd2, crt_pkg::MAP_FULL, crt_pkg::POL_SC);
        send_word(32'h0000_0010);
        send_word(32'h0000_0020);
        send_word(32'h0000_0010);
        send_word(32'h0000_0030);
        send_word(32'h0000_0040);
        send_word(32'h0000_0050);
        configure(4'd0, crt_pkg::MAP_RESERVED, crt_pkg::POL_RESERVED);
        send_word(32'h0000_0070);
        send_word(32'h0001_0070);
        configure(4'd15, crt_pkg::MAP_FOUR, crt_pkg::POL_SC);
        send_word(32'h5555_5550);
        send_word(32'hAAAA_AAA0);

        for (int ph = 0; ph < 20; ph++)
        begin
            lg = (ph % 4 == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(2, 5));
            mode = 2'($urandom_range(0, 3));
            pol = 2'($urandom_range(0, 3));
            if (ph == 19)
            begin
                lg = 4'd10;
                mode = crt_pkg::MAP_FULL;
                pol = crt_pkg::POL_LRU;
            end
            configure(lg, mode, pol);
            for (int i = 0; i < 8; i++)
                hot_addrs[i] = 32'($urandom()) << 4;
            for (int k = 0; k < 24; k++)
            begin
                send_word(pick_address());
                idle_gap();
            end
        end
        drain();
        $display("Sent %0d words over 20+ configurations: %0d hits, %0d fills, %0d evictions.",
                 words_sent, sb.hits, sb.fills, sb.evicts);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("[cache_replacement_tracker] OK");
        else
            $display("[cache_replacement_tracker] ERROR");
        $finish;
    end

endmodule

### filelist.f
src/crt_pkg.sv
src/crt_ctrl.sv
src/crt_datapath.sv
src/cache_replacement_tracker.sv
bench/tb_cache_replacement_tracker.sv
